// ----- hdl/rpn2_pkg.sv -----
// shared types, codes and helpers of the two-digit rpn calculator
package rpn2_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned OPND_W  = 7;
    localparam int unsigned ANS_W   = 15;
    localparam int unsigned POINT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_DIGIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_OPER  = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPER   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ANSWER = 2'd3;

    localparam logic [POINT_W-1:0] POINT_INT = 2'd0;
    localparam logic [POINT_W-1:0] POINT_TWO = 2'd2;
    localparam logic [POINT_W-1:0] POINT_THR = 2'd3;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [OPND_W-1:0]  OPND_MAX  = 7'd99;
    localparam logic [DIGIT_W-1:0] TEN       = 4'd10;

    // floor(x / 10) as (x * 205) >> 11, exact for x below 1029
    localparam logic [7:0]  RECIP_10    = 8'd205;
    localparam int unsigned RECIP_SHIFT = 11;

    // rounded quotient = floor((2 * a * 10^p + b) / (2 * b))
    localparam int unsigned NUM_W     = 18;
    localparam int unsigned DEN_W     = OPND_W + 1;
    localparam int unsigned REM_W     = DEN_W;
    localparam logic [10:0] SCALE_P2  = 11'd200;
    localparam logic [10:0] SCALE_P3  = 11'd2000;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic apply;
        logic div_step;
        logic div_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_start;
        logic div_last;
    } t_dp_status;

    function automatic logic [OPND_W-1:0] shift_digit(input logic [OPND_W-1:0] cur,
                                                      input logic [DIGIT_W-1:0] d);
        logic [OPND_W+7:0]  prod;
        logic [DIGIT_W-1:0] tens;
        logic [OPND_W-1:0]  units;
        prod  = (OPND_W+8)'(cur) * (OPND_W+8)'(RECIP_10);
        tens  = prod[RECIP_SHIFT +: DIGIT_W];
        units = cur - OPND_W'(tens) * OPND_W'(TEN);
        return OPND_W'(units[DIGIT_W-1:0]) * OPND_W'(TEN) + OPND_W'(d);
    endfunction

endpackage

// ----- hdl/rpn2_key_if.sv -----
// key event channel
interface rpn2_key_if;
    logic                         valid;
    logic                         ready;
    logic [rpn2_pkg::FUNC_W-1:0]  func;
    logic [rpn2_pkg::DIGIT_W-1:0] digit;
    logic [rpn2_pkg::OP_W-1:0]    op;

    modport source (output valid, func, digit, op, input ready);
    modport sink   (input valid, func, digit, op, output ready);
endinterface

// ----- hdl/rpn2_disp_if.sv -----
// display state channel
interface rpn2_disp_if;
    logic                                valid;
    logic                                ready;
    logic [rpn2_pkg::MODE_W-1:0]         mode_now;
    logic [rpn2_pkg::OPND_W-1:0]         first_value;
    logic [rpn2_pkg::OPND_W-1:0]         second_value;
    logic signed [rpn2_pkg::ANS_W-1:0]   answer;
    logic [rpn2_pkg::POINT_W-1:0]        point_place;

    modport source (output valid, mode_now, first_value, second_value, answer, point_place,
                    input ready);
    modport sink   (input valid, mode_now, first_value, second_value, answer, point_place,
                    output ready);
endinterface

// ----- hdl/rpn2_datapath.sv -----
// calculator state registers, key decode and restoring divider
module rpn2_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpn2_pkg::t_dp_cmd            i_cmd,
    input  logic [rpn2_pkg::FUNC_W-1:0]  i_func,
    input  logic [rpn2_pkg::DIGIT_W-1:0] i_digit,
    input  logic [rpn2_pkg::OP_W-1:0]    i_op,
    output rpn2_pkg::t_dp_status         o_status,
    output logic [rpn2_pkg::MODE_W-1:0]  o_mode,
    output logic [rpn2_pkg::OPND_W-1:0]  o_first,
    output logic [rpn2_pkg::OPND_W-1:0]  o_second,
    output logic [rpn2_pkg::ANS_W-1:0]   o_answer,
    output logic [rpn2_pkg::POINT_W-1:0] o_point
);

    logic [rpn2_pkg::MODE_W-1:0]  r_mode,   n_mode;
    logic [rpn2_pkg::OPND_W-1:0]  r_first,  n_first;
    logic [rpn2_pkg::OPND_W-1:0]  r_second, n_second;
    logic [rpn2_pkg::ANS_W-1:0]   r_answer, n_answer;
    logic [rpn2_pkg::POINT_W-1:0] r_point,  n_point;

    logic [rpn2_pkg::NUM_W-1:0] r_num, n_num;
    logic [rpn2_pkg::DEN_W-1:0] r_den, n_den;
    logic [rpn2_pkg::REM_W-1:0] r_rem, n_rem;
    logic [rpn2_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_p3,  n_p3;

    logic                         div_start;
    logic                         ge10;
    logic [9:0]                   ten_b;
    logic [rpn2_pkg::NUM_W-1:0]   num_init;
    logic [rpn2_pkg::REM_W:0]     rem_sh;
    logic                         qbit;
    logic [rpn2_pkg::NUM_W-1:0]   num_step;
    logic [rpn2_pkg::REM_W-1:0]   rem_step;

    assign div_start = (i_func == rpn2_pkg::FUNC_OPER) && (r_mode == rpn2_pkg::MODE_OPER)
                       && (i_op == rpn2_pkg::OP_DIV) && (r_second != '0);

    // two decimal places when the quotient reaches ten, else three
    assign ten_b    = 10'(r_second) * 10'(rpn2_pkg::TEN);
    assign ge10     = 10'(r_first) >= ten_b;
    assign num_init = (ge10 ? rpn2_pkg::NUM_W'(r_first) * rpn2_pkg::NUM_W'(rpn2_pkg::SCALE_P2)
                            : rpn2_pkg::NUM_W'(r_first) * rpn2_pkg::NUM_W'(rpn2_pkg::SCALE_P3))
                      + rpn2_pkg::NUM_W'(r_second);

    assign rem_sh   = {r_rem, r_num[rpn2_pkg::NUM_W-1]};
    assign qbit     = rem_sh >= {1'b0, r_den};
    assign rem_step = qbit ? rpn2_pkg::REM_W'(rem_sh - {1'b0, r_den})
                           : rem_sh[rpn2_pkg::REM_W-1:0];
    assign num_step = {r_num[rpn2_pkg::NUM_W-2:0], qbit};

    always_comb begin
        n_mode   = r_mode;
        n_first  = r_first;
        n_second = r_second;
        n_answer = r_answer;
        n_point  = r_point;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_p3     = r_p3;
        if (i_cmd.apply) begin
            priority if (i_func == rpn2_pkg::FUNC_DIGIT) begin
                if (i_digit <= rpn2_pkg::DIGIT_MAX) begin
                    priority if (r_mode == rpn2_pkg::MODE_FIRST
                                 || r_mode == rpn2_pkg::MODE_ANSWER) begin
                        n_mode  = rpn2_pkg::MODE_FIRST;
                        n_first = rpn2_pkg::shift_digit(r_first, i_digit);
                    end else if (r_mode == rpn2_pkg::MODE_SECOND) begin
                        n_second = rpn2_pkg::shift_digit(r_second, i_digit);
                    end else begin
                        n_mode = r_mode;
                    end
                end
            end else if (i_func == rpn2_pkg::FUNC_ENTER) begin
                unique case (r_mode)
                    rpn2_pkg::MODE_FIRST:  n_mode = rpn2_pkg::MODE_SECOND;
                    rpn2_pkg::MODE_SECOND: n_mode = rpn2_pkg::MODE_OPER;
                    rpn2_pkg::MODE_ANSWER: n_mode = rpn2_pkg::MODE_SECOND;
                    default:               n_mode = r_mode;
                endcase
            end else if (i_func == rpn2_pkg::FUNC_OPER) begin
                if (r_mode == rpn2_pkg::MODE_OPER) begin
                    n_mode   = rpn2_pkg::MODE_ANSWER;
                    n_first  = '0;
                    n_second = '0;
                    n_point  = rpn2_pkg::POINT_INT;
                    unique case (i_op)
                        rpn2_pkg::OP_ADD: begin
                            n_answer = rpn2_pkg::ANS_W'(r_first) + rpn2_pkg::ANS_W'(r_second);
                        end
                        rpn2_pkg::OP_SUB: begin
                            n_answer = rpn2_pkg::ANS_W'(r_first) - rpn2_pkg::ANS_W'(r_second);
                        end
                        rpn2_pkg::OP_MUL: begin
                            n_answer = rpn2_pkg::ANS_W'(r_first) * rpn2_pkg::ANS_W'(r_second);
                        end
                        default: begin
                            n_answer = '0;
                            n_num    = num_init;
                            n_den    = {r_second, 1'b0};
                            n_rem    = '0;
                            n_cnt    = '0;
                            n_p3     = !ge10;
                        end
                    endcase
                end
            end else begin
                n_mode = r_mode;
            end
        end
        if (i_cmd.div_step) begin
            n_num = num_step;
            n_rem = rem_step;
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.div_finish) begin
            n_answer = num_step[rpn2_pkg::ANS_W-1:0];
            n_point  = r_p3 ? rpn2_pkg::POINT_THR : rpn2_pkg::POINT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rpn2_pkg::MODE_FIRST;
            r_first  <= '0;
            r_second <= '0;
            r_answer <= '0;
            r_point  <= rpn2_pkg::POINT_INT;
            r_cnt    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_first  <= n_first;
            r_second <= n_second;
            r_answer <= n_answer;
            r_point  <= n_point;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_p3  <= n_p3;
    end

    assign o_status.div_start = div_start;
    assign o_status.div_last  = r_cnt == rpn2_pkg::DIV_LAST;
    assign o_mode   = r_mode;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_answer = r_answer;
    assign o_point  = r_point;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den != '0) && (r_rem < r_den))
        else $error("divider remainder out of range");

    a_operand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first <= rpn2_pkg::OPND_MAX) && (r_second <= rpn2_pkg::OPND_MAX))
        else $error("operand above two digits");

endmodule

// ----- hdl/rpn2_ctrl.sv -----
// handshake and divide sequencing state machine
module rpn2_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  rpn2_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output rpn2_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;
    logic   accept;
    logic   finish;

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept   = i_in_valid && in_ready;
    assign finish   = (r_state == S_DIV) && i_status.div_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_status.div_start) n_state = S_DIV;
            S_DIV:  if (i_status.div_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        priority if (accept && !i_status.div_start) begin
            n_out_valid = 1'b1;
        end else if (finish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready       = in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_cmd.apply      = accept;
    assign o_cmd.div_step   = r_state == S_DIV;
    assign o_cmd.div_finish = finish;

    a_no_word_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_out_valid)
        else $error("display word valid during divide");

    a_divide_entered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.div_start) |=> (r_state == S_DIV))
        else $error("divide key did not start divider");

    a_divide_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_state == S_IDLE) && r_out_valid)
        else $error("divide end did not present word");

endmodule

// ----- hdl/two_digit_rpn_calculator.sv -----
// top level of the two-digit rpn calculator
// each accepted key word yields one display word holding the mode, both operands, the
// answer and its point place after that key; digit, enter, add, subtract, multiply and
// divide by zero words are ready in the cycle after acceptance, a divide takes acceptance
// plus 18 steps of a one-bit-per-cycle restoring divider that produces the rounded
// four-digit quotient; a new key word is taken when no divide is running and
// the previous display word is gone or is being taken in the same cycle
module two_digit_rpn_calculator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpn2_key_if.sink    i_key,
    rpn2_disp_if.source o_disp
);

    rpn2_pkg::t_dp_cmd                cmd;
    rpn2_pkg::t_dp_status             status;
    logic [rpn2_pkg::ANS_W-1:0]       answer;

    rpn2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .i_out_ready (o_disp.ready),
        .i_status    (status),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_disp.valid),
        .o_cmd       (cmd)
    );

    rpn2_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_func   (i_key.func),
        .i_digit  (i_key.digit),
        .i_op     (i_key.op),
        .o_status (status),
        .o_mode   (o_disp.mode_now),
        .o_first  (o_disp.first_value),
        .o_second (o_disp.second_value),
        .o_answer (answer),
        .o_point  (o_disp.point_place)
    );

    assign o_disp.answer = $signed(answer);

endmodule
